FILE: sv/kldp_pkg.sv
package kldp_pkg;

  localparam int NUM_DIRS = 8;
  localparam int TAPS = 3;
  localparam int PATTERN_W = 8;
  localparam int BIN_W = 6;
  localparam int COUNT_W = 3;
  localparam int BIN_COUNT = 56;
  localparam int PATTERN_ONES = 3;
  localparam logic [COUNT_W-1:0] TOP_COUNT_RESET = 3'd3;
  localparam logic [COUNT_W-1:0] TOP_COUNT_BINNED = 3'd3;

  typedef logic [2:0] nbr_t;
  typedef logic [PATTERN_W-1:0] pattern_t;
  typedef logic [BIN_W-1:0] bin_t;
  typedef logic [COUNT_W-1:0] count_t;

  // neighbor order: nw, n, ne, w, e, sw, s, se
  localparam nbr_t NBR_NW = 3'd0;
  localparam nbr_t NBR_N  = 3'd1;
  localparam nbr_t NBR_NE = 3'd2;
  localparam nbr_t NBR_W  = 3'd3;
  localparam nbr_t NBR_E  = 3'd4;
  localparam nbr_t NBR_SW = 3'd5;
  localparam nbr_t NBR_S  = 3'd6;
  localparam nbr_t NBR_SE = 3'd7;

  // neighbors under the +5 weights of each compass mask
  localparam nbr_t STRONG_TAP [NUM_DIRS][TAPS] = '{
    '{NBR_NE, NBR_E,  NBR_SE},
    '{NBR_N,  NBR_NE, NBR_E},
    '{NBR_NW, NBR_N,  NBR_NE},
    '{NBR_NW, NBR_N,  NBR_W},
    '{NBR_NW, NBR_W,  NBR_SW},
    '{NBR_W,  NBR_SW, NBR_S},
    '{NBR_SW, NBR_S,  NBR_SE},
    '{NBR_E,  NBR_S,  NBR_SE}
  };

  // position of a three-bit pattern in descending order, 0 when not found
  function automatic bin_t bin_of(input pattern_t pattern);
    bin_t result;
    int p;
    pattern_t v;
    result = '0;
    p = 0;
    for (int hi = PATTERN_W - 1; hi >= 2; hi--) begin
      for (int mid = hi - 1; mid >= 1; mid--) begin
        for (int lo = mid - 1; lo >= 0; lo--) begin
          v = pattern_t'((1 << hi) | (1 << mid) | (1 << lo));
          if (v == pattern) begin
            result = bin_t'(p);
          end
          p = p + 1;
        end
      end
    end
    return result;
  endfunction

endpackage

FILE: sv/kldp_if.sv
interface kldp_in_if #(parameter int PIXEL_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pix_nw;
  logic [PIXEL_BITS-1:0] pix_n;
  logic [PIXEL_BITS-1:0] pix_ne;
  logic [PIXEL_BITS-1:0] pix_w;
  logic [PIXEL_BITS-1:0] pix_e;
  logic [PIXEL_BITS-1:0] pix_sw;
  logic [PIXEL_BITS-1:0] pix_s;
  logic [PIXEL_BITS-1:0] pix_se;

  modport source (
    output valid, pix_nw, pix_n, pix_ne, pix_w, pix_e, pix_sw, pix_s, pix_se,
    input  ready
  );
  modport sink (
    input  valid, pix_nw, pix_n, pix_ne, pix_w, pix_e, pix_sw, pix_s, pix_se,
    output ready
  );
endinterface

interface kldp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_bits;
  logic [5:0] bin_index;

  modport source (
    output valid, pattern_bits, bin_index,
    input  ready
  );
  modport sink (
    input  valid, pattern_bits, bin_index,
    output ready
  );
endinterface

FILE: sv/kldp_sum.sv
module kldp_sum import kldp_pkg::*; #(
  parameter int PIXEL_BITS = 8,
  localparam int SumW = PIXEL_BITS + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  kldp_in_if.sink                        in_ch,
  output logic                           sum_valid,
  input  logic                           sum_ready,
  output logic [NUM_DIRS-1:0][SumW-1:0]  sums
);

  logic [PIXEL_BITS-1:0]          pix [NUM_DIRS];
  logic [NUM_DIRS-1:0][SumW-1:0]  sums_nxt;
  logic [NUM_DIRS-1:0][SumW-1:0]  sums_r;
  logic                           valid_r;
  logic                           load;

  assign pix[NBR_NW] = in_ch.pix_nw;
  assign pix[NBR_N]  = in_ch.pix_n;
  assign pix[NBR_NE] = in_ch.pix_ne;
  assign pix[NBR_W]  = in_ch.pix_w;
  assign pix[NBR_E]  = in_ch.pix_e;
  assign pix[NBR_SW] = in_ch.pix_sw;
  assign pix[NBR_S]  = in_ch.pix_s;
  assign pix[NBR_SE] = in_ch.pix_se;

  // response k = 8 * (sum under the +5 weights) - 3 * (sum of all neighbours),
  // so the order of the responses is the order of these triple sums
  always_comb begin
    for (int k = 0; k < NUM_DIRS; k++) begin
      sums_nxt[k] = SumW'(pix[STRONG_TAP[k][0]]) + SumW'(pix[STRONG_TAP[k][1]])
                  + SumW'(pix[STRONG_TAP[k][2]]);
    end
  end

  assign load        = !valid_r || sum_ready;
  assign in_ch.ready = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_ch.valid) begin
      sums_r <= sums_nxt;
    end
  end

  assign sum_valid = valid_r;
  assign sums      = sums_r;

endmodule

FILE: sv/kldp_rank.sv
module kldp_rank import kldp_pkg::*; #(
  parameter int PIXEL_BITS = 8,
  localparam int SumW = PIXEL_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  count_t                        top_count,
  input  logic                          sum_valid,
  output logic                          sum_ready,
  input  logic [NUM_DIRS-1:0][SumW-1:0] sums,
  output logic                          pat_valid,
  input  logic                          pat_ready,
  output pattern_t                      pattern
);

  // beat[j][k]: direction j ranks ahead of direction k
  logic [NUM_DIRS-1:0][NUM_DIRS-1:0] beat_nxt;
  logic [NUM_DIRS-1:0][NUM_DIRS-1:0] beat_r;
  logic                              cmp_valid_r;
  logic                              cmp_load;
  pattern_t                          pattern_nxt;
  pattern_t                          pattern_r;
  logic                              pat_valid_r;
  logic                              pat_load;
  count_t                            rank [NUM_DIRS];

  // ties go to the lower direction index
  always_comb begin
    for (int j = 0; j < NUM_DIRS; j++) begin
      for (int k = 0; k < NUM_DIRS; k++) begin
        if (j < k) begin
          beat_nxt[j][k] = sums[j] >= sums[k];
        end else if (j > k) begin
          beat_nxt[j][k] = sums[j] > sums[k];
        end else begin
          beat_nxt[j][k] = 1'b0;
        end
      end
    end
  end

  assign pat_load  = !pat_valid_r || pat_ready;
  assign cmp_load  = !cmp_valid_r || pat_load;
  assign sum_ready = cmp_load;

  always_comb begin
    for (int k = 0; k < NUM_DIRS; k++) begin
      rank[k] = '0;
      for (int j = 0; j < NUM_DIRS; j++) begin
        rank[k] = rank[k] + count_t'(beat_r[j][k]);
      end
      pattern_nxt[PATTERN_W-1-k] = rank[k] < top_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
      pat_valid_r <= 1'b0;
    end else begin
      if (cmp_load) begin
        cmp_valid_r <= sum_valid;
      end
      if (pat_load) begin
        pat_valid_r <= cmp_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_load && sum_valid) begin
      beat_r <= beat_nxt;
    end
    if (pat_load && cmp_valid_r) begin
      pattern_r <= pattern_nxt;
    end
  end

  assign pat_valid = pat_valid_r;
  assign pattern   = pattern_r;

endmodule

FILE: sv/kldp_bin.sv
module kldp_bin import kldp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  count_t     top_count,
  input  logic       pat_valid,
  output logic       pat_ready,
  input  pattern_t   pattern,
  kldp_out_if.source out_ch
);

  logic     valid_r;
  logic     load;
  pattern_t pattern_r;
  bin_t     bin_nxt;
  bin_t     bin_r;

  assign bin_nxt   = (top_count == TOP_COUNT_BINNED) ? bin_of(pattern) : '0;
  assign load      = !valid_r || out_ch.ready;
  assign pat_ready = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= pat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pat_valid) begin
      pattern_r <= pattern;
      bin_r     <= bin_nxt;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.pattern_bits = pattern_r;
  assign out_ch.bin_index    = bin_r;

endmodule

FILE: sv/kirsch_local_directional_pattern_unit.sv
// Kirsch local directional pattern of one 3x3 neighborhood. Each transfer on
// in_ch carries the eight neighbors of a pixel; the result on out_ch gives the
// pattern with bit 7-k set for the top_count strongest of the eight compass
// responses (ties to the lower direction) and, when top_count is 3, the bin
// index 0..55 of that pattern, otherwise 0. The block takes one item every
// cycle while out_ch is not stalled; a result passes through a four-stage
// register pipeline: triple sums, pairwise compares, rank count, and bin
// lookup in the output register. Each stage holds while the stage after it
// is full and stalled, so backpressure on out_ch reaches in_ch.ready without
// loss. top_count resets to 3 and is written through cfg_we/cfg_wdata; the
// user must write it only while idle, which the block itself does not enforce.
module kirsch_local_directional_pattern_unit import kldp_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  count_t       cfg_wdata,
  kldp_in_if.sink      in_ch,
  kldp_out_if.source   out_ch
);

  localparam int SumW = PIXEL_BITS + 2;

  count_t                        top_count_r;
  logic                          sum_valid;
  logic                          sum_ready;
  logic [NUM_DIRS-1:0][SumW-1:0] sums;
  logic                          pat_valid;
  logic                          pat_ready;
  pattern_t                      pattern;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TOP_COUNT_RESET;
    end else if (cfg_we) begin
      top_count_r <= cfg_wdata;
    end
  end

  kldp_sum #(.PIXEL_BITS(PIXEL_BITS)) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sums      (sums)
  );

  kldp_rank #(.PIXEL_BITS(PIXEL_BITS)) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .top_count (top_count_r),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sums      (sums),
    .pat_valid (pat_valid),
    .pat_ready (pat_ready),
    .pattern   (pattern)
  );

  kldp_bin u_bin (
    .clk       (clk),
    .rst_n     (rst_n),
    .top_count (top_count_r),
    .pat_valid (pat_valid),
    .pat_ready (pat_ready),
    .pattern   (pattern),
    .out_ch    (out_ch)
  );

  // an accepted item is always held in the first stage on the next cycle
  a_accept_fills_stage: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> sum_valid
  ) else $error("accepted item did not reach the sum stage");

  a_bin_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.bin_index < BIN_W'(BIN_COUNT)
  ) else $error("bin index out of range");

  a_bin_needs_three_bits: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bin_index != '0
      |-> $countones(out_ch.pattern_bits) == PATTERN_ONES
  ) else $error("nonzero bin index without a three-bit pattern");

endmodule

FILE: dv/kldp_code_checker.sv
module kldp_code_checker import kldp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  count_t cfg_wdata,
  kldp_in_if     in_ch,
  kldp_out_if    out_ch,
  output int     fail_count,
  output int     pending,
  output int     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pattern_t pattern;
    bin_t     bin;
  } ldp_code_t;

  // compass weights over the 3x3 window, row-major, center weight zero
  localparam int KIRSCH_WEIGHT [NUM_DIRS][9] = '{
    '{-3, -3,  5, -3, 0,  5, -3, -3,  5},
    '{-3,  5,  5, -3, 0,  5, -3, -3, -3},
    '{ 5,  5,  5, -3, 0, -3, -3, -3, -3},
    '{ 5,  5, -3,  5, 0, -3, -3, -3, -3},
    '{ 5, -3, -3,  5, 0, -3,  5, -3, -3},
    '{-3, -3, -3,  5, 0, -3,  5,  5, -3},
    '{-3, -3, -3, -3, 0, -3,  5,  5,  5},
    '{-3, -3, -3, -3, 0,  5, -3,  5,  5}
  };

  count_t    top_now;
  ldp_code_t code_fifo [$];

  function automatic ldp_code_t predict_code(input int win [9], input count_t top);
    ldp_code_t code;
    int resp [NUM_DIRS];
    int rank;
    int hi;
    int mid;
    int lo;
    int pos;
    code = '0;
    for (int k = 0; k < NUM_DIRS; k++) begin
      resp[k] = 0;
      for (int t = 0; t < 9; t++) begin
        resp[k] += KIRSCH_WEIGHT[k][t] * win[t];
      end
    end
    for (int k = 0; k < NUM_DIRS; k++) begin
      rank = 0;
      for (int j = 0; j < NUM_DIRS; j++) begin
        if (resp[j] > resp[k] || (resp[j] == resp[k] && j < k)) begin
          rank++;
        end
      end
      if (rank < int'(top)) begin
        code.pattern[PATTERN_W-1-k] = 1'b1;
      end
    end
    // table position: triples ordered by high, middle, low bit, all descending
    if (top == TOP_COUNT_BINNED && $countones(code.pattern) == PATTERN_ONES) begin
      hi = -1;
      mid = -1;
      lo = -1;
      for (int b = PATTERN_W - 1; b >= 0; b--) begin
        if (code.pattern[b]) begin
          if (hi < 0) hi = b;
          else if (mid < 0) mid = b;
          else lo = b;
        end
      end
      pos = mid - 1 - lo;
      for (int h = hi + 1; h < PATTERN_W; h++) pos += h * (h - 1) / 2;
      for (int m = mid + 1; m < hi; m++) pos += m;
      code.bin = bin_t'(pos);
    end
    return code;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin
    ldp_code_t want;
    int win [9];
    if (!rst_n) begin
      code_fifo.delete();
      top_now = TOP_COUNT_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (code_fifo.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", checked));
        end else begin
          want = code_fifo.pop_front();
          if (out_ch.pattern_bits !== want.pattern || out_ch.bin_index !== want.bin) begin
            report_mismatch($sformatf("result %0d: pattern %b bin %0d, want %b bin %0d",
                                      checked, out_ch.pattern_bits, out_ch.bin_index,
                                      want.pattern, want.bin));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        win = '{int'(in_ch.pix_nw), int'(in_ch.pix_n), int'(in_ch.pix_ne),
                int'(in_ch.pix_w), 0, int'(in_ch.pix_e),
                int'(in_ch.pix_sw), int'(in_ch.pix_s), int'(in_ch.pix_se)};
        code_fifo = {code_fifo, predict_code(win, top_now)};
      end
      if (cfg_we) begin
        top_now = cfg_wdata;
      end
    end
    pending = code_fifo.size();
  end

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kldp_pkg::*;

  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AFTER = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 210;
  localparam count_t PHASE_TOP [PHASES] = '{3'd1, 3'd7, 3'd0, 3'd2, 3'd5, 3'd4, 3'd6, 3'd3};

  typedef struct packed {
    logic [7:0] nw;
    logic [7:0] n;
    logic [7:0] ne;
    logic [7:0] w;
    logic [7:0] e;
    logic [7:0] sw;
    logic [7:0] s;
    logic [7:0] se;
  } nbhd_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;
  int     fail_count;
  int     pending;
  int     checked;
  int     stall_pct;

  kldp_in_if #(.PIXEL_BITS(8)) in_bus ();
  kldp_out_if out_bus ();

  kirsch_local_directional_pattern_unit #(.PIXEL_BITS(8)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  kldp_code_checker code_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic nbhd_t random_nbhd();
    logic [7:0] v [8];
    logic [7:0] a;
    logic [7:0] b;
    int mode;
    int base;
    mode = $urandom_range(0, 9);
    a = 8'($urandom);
    b = 8'($urandom);
    for (int i = 0; i < 8; i++) begin
      case (mode)
        4: begin
          v[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        5: begin
          v[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : a;
        end
        6: begin
          base = int'(a) + int'($urandom_range(0, 6)) - 3;
          if (base < 0) base = 0;
          else if (base > 255) base = 255;
          v[i] = 8'(base);
        end
        7: begin
          v[i] = $urandom_range(0, 1) ? a : b;
        end
        8: begin
          v[i] = 8'($urandom_range(0, 15));
        end
        9: begin
          v[i] = 8'($urandom_range(240, 255));
        end
        default: begin
          v[i] = 8'($urandom);
        end
      endcase
    end
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  // called and returns at a falling edge
  task automatic offer(input nbhd_t px);
    if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.pix_nw <= px.nw;
    in_bus.pix_n  <= px.n;
    in_bus.pix_ne <= px.ne;
    in_bus.pix_w  <= px.w;
    in_bus.pix_e  <= px.e;
    in_bus.pix_sw <= px.sw;
    in_bus.pix_s  <= px.s;
    in_bus.pix_se <= px.se;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic set_top_count(input count_t value);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls plus one long hold to back up the input
  initial begin
    int hold_count;
    bit held;
    held = 1'b0;
    out_bus.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
        out_bus.ready <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    nbhd_t px;
    int pct_choice [4];
    pct_choice = '{0, 8, 25, 50};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stall_pct = 0;
    in_bus.valid = 1'b0;
    in_bus.pix_nw = '0;
    in_bus.pix_n = '0;
    in_bus.pix_ne = '0;
    in_bus.pix_w = '0;
    in_bus.pix_e = '0;
    in_bus.pix_sw = '0;
    in_bus.pix_s = '0;
    in_bus.pix_se = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: flat windows, lone bright and lone dark neighbors, stripes, ramp
    offer('0);
    offer('1);
    for (int i = 0; i < 8; i++) begin
      px = nbhd_t'(64'hFF << (8 * i));
      offer(px);
      offer(~px);
    end
    offer(64'hFF00_FF00_FF00_FF00);
    offer(64'h00FF_00FF_00FF_00FF);
    offer(64'h0024_496D_92B6_DBFF);

    stall_pct = 25;
    repeat (70) offer(random_nbhd());

    for (int p = 0; p < PHASES; p++) begin
      stall_pct = (p == PHASES - 1) ? 0 : pct_choice[$urandom_range(0, 3)];
      set_top_count(PHASE_TOP[p]);
      repeat (PHASE_ITEMS) offer(random_nbhd());
    end

    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d neighborhoods: flat, lone-pixel, striped and tied windows",
             checked);
    $display("top_count swept 0..7, random stalls both sides, one %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
